// ===== rtl/skf_pkg.sv =====
// Package for the scalar Kalman filter: shared constants and types.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package skf_pkg;

   // Default data format: signed Q16.16 samples
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // Configuration register map
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PROCESS_NOISE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MEASURE_NOISE = 1'd1;

   // Integer parts of the noise reset values (Q = 20.0, R = 200.0)
   localparam int PROC_NOISE_RESET_INT = 20;
   localparam int MEAS_NOISE_RESET_INT = 200;

   // Control of the shared adder/subtractor
   typedef struct packed {
      logic sub;   // 1: a - b, 0: a + b
   } alu_ctl_type;

endpackage

// ===== rtl/skf_req_if.sv =====
// Request channel of the scalar Kalman filter: valid/ready plus one measurement.
// Depends on skf_pkg for the default data width.
`timescale 1ns / 1ps

interface skf_req_if
   import skf_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] measurement;

   modport source (output valid, output measurement, input ready);
   modport sink   (input valid, input measurement, output ready);
endinterface

// ===== rtl/skf_rsp_if.sv =====
// Response channel of the scalar Kalman filter: valid/ready plus one estimate.
// Depends on skf_pkg for the default data width.
`timescale 1ns / 1ps

interface skf_rsp_if
   import skf_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] estimate;

   modport source (output valid, output estimate, input ready);
   modport sink   (input valid, input estimate, output ready);
endinterface

// ===== rtl/skf_alu.sv =====
// Shared adder/subtractor of the scalar Kalman filter datapath.
// Depends on skf_pkg for the control struct.
`timescale 1ns / 1ps

module skf_alu
   import skf_pkg::*;
#(
   parameter int WIDTH = DATA_WIDTH_DEF + FRAC_BITS_DEF + 3
) (
   input  alu_ctl_type      ctl,
   input  logic [WIDTH-1:0] opa,
   input  logic [WIDTH-1:0] opb,
   output logic [WIDTH-1:0] result
);

   logic [WIDTH-1:0] opb_eff;

   // Invert b and add a carry in for subtraction
   assign opb_eff = ctl.sub ? ~opb : opb;
   assign result  = opa + opb_eff + {{(WIDTH-1){1'b0}}, ctl.sub};

endmodule

// ===== rtl/skf_csr.sv =====
// Configuration registers of the scalar Kalman filter: process and measurement noise.
// Depends on skf_pkg for the register map and reset values.
`timescale 1ns / 1ps

module skf_csr
   import skf_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_write_data,
   output logic [DATA_WIDTH-1:0]      process_noise,
   output logic [DATA_WIDTH-1:0]      measure_noise
);

   localparam logic [DATA_WIDTH-1:0] PN_RESET =
      DATA_WIDTH'(PROC_NOISE_RESET_INT) << FRAC_BITS;
   localparam logic [DATA_WIDTH-1:0] MN_RESET =
      DATA_WIDTH'(MEAS_NOISE_RESET_INT) << FRAC_BITS;

   logic [DATA_WIDTH-1:0] pn_ff, pn_in;
   logic [DATA_WIDTH-1:0] mn_ff, mn_in;

   // Decode the write
   always_comb begin
      pn_in = pn_ff;
      mn_in = mn_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_PROCESS_NOISE: pn_in = csr_write_data;
            REG_MEASURE_NOISE: mn_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pn_ff <= PN_RESET;
         mn_ff <= MN_RESET;
      end else begin
         pn_ff <= pn_in;
         mn_ff <= mn_in;
      end
   end

   assign process_noise = pn_ff;
   assign measure_noise = mn_ff;

endmodule

// ===== rtl/scalar_kalman_filter.sv =====
// Top level of the scalar Kalman filter: sequencer, state and datapath registers.
// Depends on skf_pkg, skf_req_if, skf_rsp_if, skf_alu and skf_csr.
`timescale 1ns / 1ps

// One-dimensional Kalman filter (A = 1, B = 0, H = 1) on signed fixed-point samples
// (DATA_WIDTH bits, FRAC_BITS fraction bits). Each request carries one measurement and
// yields one response with the updated estimate; estimate and covariance start at zero
// after reset. All arithmetic runs through one shared adder/subtractor under a small
// sequencer: the idle cycle that takes the request, three single add steps, a restoring
// gain division (FRAC_BITS+1 steps), two shift-add multiplies (FRAC_BITS+1 steps each)
// and four finishing steps (estimate update, one minus gain, covariance saturation and
// response handoff). While a request occupies the block, req.ready is low; the handoff
// step waits while the previous response is still held in the output register.
// The response sits in that output register so the next request is taken while it
// waits. Noise registers are to be written through the csr_ port while the block is
// idle; a rule for the user that the block does not enforce. The default is Q16.16.

module scalar_kalman_filter
   import skf_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   skf_req_if.sink                    req,
   skf_rsp_if.source                  rsp,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_write_data
);

   localparam int DW = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int AW = DW + F + 3;
   localparam int CW = $clog2(F + 1);

   // Sequencer codes
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_PRED    = 4'd1;
   localparam logic [3:0] S_DSUM    = 4'd2;
   localparam logic [3:0] S_INNOV   = 4'd3;
   localparam logic [3:0] S_DIV     = 4'd4;
   localparam logic [3:0] S_MUL_EST = 4'd5;
   localparam logic [3:0] S_EST     = 4'd6;
   localparam logic [3:0] S_HCOMP   = 4'd7;
   localparam logic [3:0] S_MUL_COV = 4'd8;
   localparam logic [3:0] S_COV     = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   localparam logic [AW-1:0] ONE_AW = {{(AW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
   localparam logic [F:0]    ONE_G  = {1'b1, {F{1'b0}}};

   logic [DW-1:0] process_noise;
   logic [DW-1:0] measure_noise;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] meas_ff, meas_in;
   logic [DW-1:0] est_ff, est_in;
   logic [DW-1:0] cov_ff, cov_in;
   logic [DW:0]   p_ff, p_in;
   logic [DW+1:0] d_ff, d_in;
   logic          dzero_ff, dzero_in;
   logic [DW+2:0] rem_ff, rem_in;
   logic [DW:0]   innov_ff, innov_in;
   logic [F:0]    gain_ff, gain_in;
   logic [F:0]    mplier_ff, mplier_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_data_ff, rsp_data_in;

   alu_ctl_type   alu_ctl;
   logic [AW-1:0] alu_a, alu_b, alu_sum;
   logic          alu_nonneg;
   logic          last_step;

   skf_csr #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .process_noise    (process_noise),
      .measure_noise    (measure_noise)
   );

   skf_alu #(
      .WIDTH (AW)
   ) u_alu (
      .ctl    (alu_ctl),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_sum)
   );

   assign alu_nonneg = ~alu_sum[AW-1];
   assign last_step  = (cnt_ff == CW'(F));

   // Route operands into the shared unit
   always_comb begin
      alu_ctl.sub = 1'b0;
      alu_a       = '0;
      alu_b       = '0;
      unique case (state_ff)
         S_PRED: begin
            alu_a = {{(AW-DW){1'b0}}, cov_ff};
            alu_b = {{(AW-DW){1'b0}}, process_noise};
         end
         S_DSUM: begin
            alu_a = {{(AW-DW-1){1'b0}}, p_ff};
            alu_b = {{(AW-DW){1'b0}}, measure_noise};
         end
         S_INNOV: begin
            alu_ctl.sub = 1'b1;
            alu_a = {{(AW-DW){meas_ff[DW-1]}}, meas_ff};
            alu_b = {{(AW-DW){est_ff[DW-1]}}, est_ff};
         end
         S_DIV: begin
            alu_ctl.sub = 1'b1;
            alu_a = (cnt_ff == '0) ? {{(AW-DW-3){1'b0}}, rem_ff}
                                   : {{(AW-DW-3){1'b0}}, rem_ff[DW+1:0], 1'b0};
            alu_b = {{(AW-DW-2){1'b0}}, d_ff};
         end
         S_MUL_EST: begin
            alu_a = {acc_ff[AW-2:0], 1'b0};
            alu_b = mplier_ff[F] ? {{(AW-DW-1){innov_ff[DW]}}, innov_ff} : '0;
         end
         S_EST: begin
            alu_a = {{(AW-DW){est_ff[DW-1]}}, est_ff};
            alu_b = {{F{acc_ff[AW-1]}}, acc_ff[AW-1:F]};
         end
         S_HCOMP: begin
            alu_ctl.sub = 1'b1;
            alu_a = ONE_AW;
            alu_b = {{(AW-F-1){1'b0}}, gain_ff};
         end
         S_MUL_COV: begin
            alu_a = {acc_ff[AW-2:0], 1'b0};
            alu_b = mplier_ff[F] ? {{(AW-DW-1){1'b0}}, p_ff} : '0;
         end
         default: ;
      endcase
   end

   // Advance the sequencer and capture results
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      meas_in      = meas_ff;
      est_in       = est_ff;
      cov_in       = cov_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      dzero_in     = dzero_ff;
      rem_in       = rem_ff;
      innov_in     = innov_ff;
      gain_in      = gain_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               meas_in  = req.measurement;
               state_in = S_PRED;
            end
         end
         S_PRED: begin
            p_in     = alu_sum[DW:0];
            state_in = S_DSUM;
         end
         S_DSUM: begin
            d_in     = alu_sum[DW+1:0];
            dzero_in = (alu_sum[DW+1:0] == '0);
            rem_in   = {2'b00, p_ff};
            state_in = S_INNOV;
         end
         S_INNOV: begin
            innov_in = alu_sum[DW:0];
            cnt_in   = '0;
            gain_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring step: keep the difference when it does not go negative
            rem_in  = alu_nonneg ? alu_sum[DW+2:0] : alu_a[DW+2:0];
            gain_in = {gain_ff[F-1:0], alu_nonneg};
            cnt_in  = cnt_ff + 1'b1;
            if (last_step) begin
               if (dzero_ff) begin
                  gain_in = '0;
               end
               mplier_in = dzero_ff ? '0 : {gain_ff[F-1:0], alu_nonneg};
               acc_in    = '0;
               cnt_in    = '0;
               state_in  = S_MUL_EST;
            end
         end
         S_MUL_EST: begin
            acc_in    = alu_sum;
            mplier_in = {mplier_ff[F-1:0], 1'b0};
            cnt_in    = cnt_ff + 1'b1;
            if (last_step) begin
               state_in = S_EST;
            end
         end
         S_EST: begin
            est_in   = alu_sum[DW-1:0];
            state_in = S_HCOMP;
         end
         S_HCOMP: begin
            mplier_in = alu_sum[F:0];
            acc_in    = '0;
            cnt_in    = '0;
            state_in  = S_MUL_COV;
         end
         S_MUL_COV: begin
            acc_in    = alu_sum;
            mplier_in = {mplier_ff[F-1:0], 1'b0};
            cnt_in    = cnt_ff + 1'b1;
            if (last_step) begin
               state_in = S_COV;
            end
         end
         S_COV: begin
            // saturate the new covariance to the data width
            cov_in   = (acc_ff[AW-1:DW+F] != '0) ? '1 : acc_ff[DW+F-1:F];
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = est_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         est_ff       <= '0;
         cov_ff       <= '0;
         dzero_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         dzero_ff     <= dzero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff     <= meas_in;
      p_ff        <= p_in;
      d_ff        <= d_in;
      rem_ff      <= rem_in;
      innov_ff    <= innov_in;
      gain_ff     <= gain_in;
      mplier_ff   <= mplier_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req.ready    = (state_ff == S_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.estimate = rsp_data_ff;

   // A response only appears out of the final sequencer step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the final step");

   // The division remainder stays below the divisor after the first step
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff != '0 && !dzero_ff) |-> ({1'b0, rem_ff} < {2'b00, d_ff}))
      else $error("division remainder out of range");

   // The gain never exceeds one
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EST) |-> (gain_ff <= ONE_G))
      else $error("gain above one");

   // The updated covariance never exceeds the predicted one
   a_cov_shrinks: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == S_COV && !$past(reset)) |-> ({1'b0, cov_ff} <= $past(p_ff)))
      else $error("covariance grew in the update");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for scalar_kalman_filter: directed rows, then random phases.
// Depends on skf_pkg, skf_req_if, skf_rsp_if and the filter RTL; needs nothing else.
`timescale 1ns / 1ps

module testbench;
   import skf_pkg::*;

   localparam int DW          = DATA_WIDTH_DEF;
   localparam int FRAC        = FRAC_BITS_DEF;
   localparam int BUSY_CYCLES = 3 * FRAC + 11;
   localparam int DRAIN_CYCLES = BUSY_CYCLES + 20;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 108;

   localparam logic [DW-1:0] MEAS_MAX = 32'h7FFF_FFFF;
   localparam logic [DW-1:0] MEAS_MIN = 32'h8000_0000;
   localparam logic [DW-1:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [DW-1:0] Q_DEFAULT = DW'(PROC_NOISE_RESET_INT) << FRAC;
   localparam logic [DW-1:0] R_DEFAULT = DW'(MEAS_NOISE_RESET_INT) << FRAC;

   typedef enum logic [1:0] {
      ROW_MEASURE,
      ROW_SET_PROCESS,
      ROW_SET_MEASURE
   } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [DW-1:0] value;
      logic          pinned;
      logic [DW-1:0] pinned_estimate;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 24;

   // Directed rows: extremes at the reset noise, zero measurement noise, zero divisor,
   // noise at its largest, and alternating bit patterns.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_MEASURE,     32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_MEASURE,     MEAS_MAX,      1'b0, 32'h0},
      '{ROW_MEASURE,     MEAS_MIN,      1'b0, 32'h0},
      '{ROW_MEASURE,     ALL_ONES,      1'b0, 32'h0},
      '{ROW_MEASURE,     32'h0001_8000, 1'b0, 32'h0},
      '{ROW_SET_MEASURE, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_MEASURE,     MEAS_MAX,      1'b1, MEAS_MAX},
      '{ROW_MEASURE,     MEAS_MIN,      1'b1, MEAS_MIN},
      '{ROW_MEASURE,     32'h0000_0001, 1'b1, 32'h0000_0001},
      '{ROW_SET_PROCESS, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_MEASURE,     32'h1234_5678, 1'b1, 32'h0000_0001},
      '{ROW_MEASURE,     MEAS_MIN,      1'b1, 32'h0000_0001},
      '{ROW_MEASURE,     MEAS_MAX,      1'b1, 32'h0000_0001},
      '{ROW_SET_MEASURE, ALL_ONES,      1'b0, 32'h0},
      '{ROW_MEASURE,     MEAS_MAX,      1'b1, 32'h0000_0001},
      '{ROW_SET_PROCESS, ALL_ONES,      1'b0, 32'h0},
      '{ROW_MEASURE,     MEAS_MAX,      1'b0, 32'h0},
      '{ROW_MEASURE,     MEAS_MIN,      1'b0, 32'h0},
      '{ROW_MEASURE,     MEAS_MAX,      1'b0, 32'h0},
      '{ROW_MEASURE,     32'h0000_0000, 1'b0, 32'h0},
      '{ROW_SET_PROCESS, 32'h0000_0001, 1'b0, 32'h0},
      '{ROW_SET_MEASURE, 32'h0000_0001, 1'b0, 32'h0},
      '{ROW_MEASURE,     32'h5555_5555, 1'b0, 32'h0},
      '{ROW_MEASURE,     32'hAAAA_AAAA, 1'b0, 32'h0}
   };

   logic          clock;
   logic          reset;
   logic          csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [DW-1:0] csr_write_data;

   skf_req_if req_ch ();
   skf_rsp_if rsp_ch ();

   scalar_kalman_filter uut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Filter state and noise settings as the block should hold them
   logic signed [DW-1:0] filt_estimate;
   logic [DW-1:0]        filt_covariance;
   logic [DW-1:0]        noise_process;
   logic [DW-1:0]        noise_measure;

   logic [DW-1:0] estimate_queue [$];
   int            mismatch_count;
   int            cycle_count;
   bit            eager_sender;
   bit            steady_receiver;
   bit            hold_off_pending;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run one Kalman update on the tracked state and return the new estimate
   function automatic logic [DW-1:0] kalman_update(input logic [DW-1:0] meas);
      logic [63:0]        p_pred;
      logic [63:0]        divisor;
      logic [63:0]        gain;
      logic [63:0]        cov_next;
      logic signed [63:0] innovation;
      logic signed [63:0] step;
      p_pred  = 64'(filt_covariance) + 64'(noise_process);
      divisor = p_pred + 64'(noise_measure);
      gain    = (divisor == 0) ? 64'd0 : (p_pred << FRAC) / divisor;
      innovation = 64'($signed(meas)) - 64'(filt_estimate);
      step = (innovation * $signed(gain)) >>> FRAC;
      filt_estimate = filt_estimate + step[DW-1:0];
      cov_next = (p_pred * ((64'd1 << FRAC) - gain)) >> FRAC;
      filt_covariance = (cov_next > 64'(ALL_ONES)) ? ALL_ONES : cov_next[DW-1:0];
      return filt_estimate;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 4);
      else
         return $urandom_range(5, 90);
   endfunction

   function automatic logic [DW-1:0] pick_measurement();
      int            roll;
      logic [DW-1:0] m;
      roll = $urandom_range(0, 99);
      m = $urandom;
      if (roll < 40) begin
         // full range as drawn
      end else if (roll < 70) begin
         m = filt_estimate + DW'($urandom_range(0, 20'hFFFFF)) - 32'h0008_0000;
      end else if (roll < 85) begin
         case ($urandom_range(0, 3))
            0: m = MEAS_MAX;
            1: m = MEAS_MIN;
            2: m = '0;
            default: m = ALL_ONES;
         endcase
      end else begin
         m = {{(DW-18){m[17]}}, m[17:0]};
      end
      return m;
   endfunction

   task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                  input logic [DW-1:0] want);
      $display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Offer one request, hold it until taken, then queue its expected estimate
   task automatic send_measurement(input logic [DW-1:0] meas, input logic pinned,
                                   input logic [DW-1:0] pinned_estimate);
      int            gap;
      logic [DW-1:0] predicted;
      gap = eager_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.measurement <= meas;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = kalman_update(meas);
      estimate_queue.push_back(pinned ? pinned_estimate : predicted);
   endtask

   // Drop valid and let the block finish everything in flight
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (estimate_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [DW-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx == REG_PROCESS_NOISE)
         noise_process = value;
      else
         noise_measure = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Receiver: random ready, with one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (steady_receiver || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat (1 + pick_gap()) @(posedge clock);
         end
      end
   end

   // Check each response against the oldest expected estimate
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (estimate_queue.size() == 0)
            report_mismatch("response with no request pending", rsp_ch.estimate, '0);
         else if (rsp_ch.estimate !== estimate_queue[0]) begin
            report_mismatch("estimate", rsp_ch.estimate, estimate_queue[0]);
            void'(estimate_queue.pop_front());
         end else
            void'(estimate_queue.pop_front());
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [DW-1:0] q_val;
      logic [DW-1:0] r_val;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.measurement <= '0;
      csr_write_enable   <= 1'b0;
      csr_index          <= REG_PROCESS_NOISE;
      csr_write_data     <= '0;
      cycle_count        = 0;
      mismatch_count     = 0;
      eager_sender       = 1'b0;
      steady_receiver    = 1'b0;
      hold_off_pending   = 1'b0;
      filt_estimate      = '0;
      filt_covariance    = '0;
      noise_process      = Q_DEFAULT;
      noise_measure      = R_DEFAULT;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed rows
      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_SET_PROCESS: write_register(REG_PROCESS_NOISE, directed_rows[i].value);
            ROW_SET_MEASURE: write_register(REG_MEASURE_NOISE, directed_rows[i].value);
            default: send_measurement(directed_rows[i].value, directed_rows[i].pinned,
                                      directed_rows[i].pinned_estimate);
         endcase
      end

      // Random phases, each under its own noise setting
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin q_val = Q_DEFAULT;            r_val = R_DEFAULT;   end
            1: begin q_val = $urandom_range(0, 32'h000F_FFFF); r_val = $urandom; end
            2: begin q_val = '0;                   r_val = $urandom;    end
            3: begin q_val = $urandom;             r_val = '0;          end
            4: begin q_val = ALL_ONES;             r_val = ALL_ONES;    end
            default: begin q_val = $urandom;       r_val = $urandom;    end
         endcase
         write_register(REG_PROCESS_NOISE, q_val);
         write_register(REG_MEASURE_NOISE, r_val);
         eager_sender    = (phase == 1) || (phase == 3);
         steady_receiver = (phase == 3);
         // Stall the receiver long enough for the block to back up into its input
         if (phase == 1)
            hold_off_pending = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_measurement(pick_measurement(), 1'b0, '0);
      end

      // Drain and finish
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (estimate_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
